[hdl/ple_pkg.sv]
// ple_pkg: shared types, codes and widths of the positional list engine
// no dependencies

package ple_pkg;

	// fixed field widths
	localparam int DATA_W = 32;
	localparam int REQ_W  = 4;
	localparam int POS_W  = 8;
	localparam int ST_W   = 3;
	localparam int OPOS_W = 5;
	localparam int OCNT_W = 5;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		RQ_INS_FRONT = 4'd0,
		RQ_INS_BACK  = 4'd1,
		RQ_INS_AT    = 4'd2,
		RQ_DEL_FRONT = 4'd3,
		RQ_DEL_BACK  = 4'd4,
		RQ_DEL_AT    = 4'd5,
		RQ_SEARCH    = 4'd6,
		RQ_UPDATE    = 4'd7,
		RQ_DUMP      = 4'd8,
		RQ_DUMP_REV  = 4'd9
	} req_code_t;

	// result status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_POP,
		ST_RESP
	} state_t;

	// kind of multi-cycle walk around the ring
	typedef enum logic [1:0] {
		K_DUMP,
		K_DUMP_REV,
		K_SRCH,
		K_DEL
	} kind_t;

	// entry move done by every cell at once
	typedef enum logic [2:0] {
		C_HOLD,
		C_INS,
		C_DEL,
		C_ROT,
		C_WR
	} cell_op_t;

	// move of the per-cell stack used to reverse a dump
	typedef enum logic [1:0] {
		S_HOLD,
		S_PUSH,
		S_POP
	} stk_op_t;

	// control broadcast to the cell row
	typedef struct packed {
		cell_op_t op;
		stk_op_t  sop;
	} cell_ctl_t;

	// one result item
	typedef struct packed {
		status_t             status;
		logic [DATA_W-1:0]   data;
		logic [OPOS_W-1:0]   pos;
		logic [OCNT_W-1:0]   cnt;
		logic                last;
	} res_t;

	function automatic res_t mk_res(status_t s, logic [DATA_W-1:0] d,
			logic [OPOS_W-1:0] p, logic [OCNT_W-1:0] c, logic l);
		res_t r;
		r.status = s;
		r.data   = d;
		r.pos    = p;
		r.cnt    = c;
		r.last   = l;
		return r;
	endfunction

endpackage

[hdl/ple_req_if.sv]
// ple_req_if: request channel of the positional list engine
// no dependencies

interface ple_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         req_type;
	logic signed [31:0] value;
	logic [7:0]         position;

	modport source(output valid, req_type, value, position, input ready);
	modport sink(input valid, req_type, value, position, output ready);
endinterface

[hdl/ple_res_if.sv]
// ple_res_if: result channel of the positional list engine
// no dependencies

interface ple_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic signed [31:0] data_out;
	logic [4:0]         position_out;
	logic [4:0]         entry_count;
	logic               last;

	modport source(output valid, status, data_out, position_out, entry_count, last,
		input ready);
	modport sink(input valid, status, data_out, position_out, entry_count, last,
		output ready);
endinterface

[hdl/positional_list_engine_top.sv]
// positional_list_engine_top: bounded ordered list held in a row of cells
// depends on ple_pkg, ple_req_if, ple_res_if, ple_cell and ple_obuf
//
// Usage: requests arrive on the req channel, results leave on the res
// channel, both valid/ready; an item moves when valid and ready are high
// at a rising edge. Entries sit in a row of cells, front of the list in
// cell zero. Insert front/back/at, delete front and update act on all
// cells at once: the item is taken and its result is pushed into the
// result buffer in the same cycle, so such requests run at one item per
// cycle while the buffer is not full. Delete back, delete at, search and
// the dumps walk the row by rotating it one cell per cycle; a forward dump
// gives one result per cycle and pauses while the buffer is full. Search
// and the two deletes give their result after the walk; a reverse dump
// fills the stack in the cells, then pops it. req.ready is low during
// such a walk. Results go through a two-entry buffer, so a new request is
// taken while one result still waits; when res stalls and the buffer
// fills, ready drops and dumps pause. Reset clears the count and the
// sequencer; the list is empty after reset and needs no clearing pass.

module positional_list_engine_top import ple_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	ple_req_if.sink   req,
	ple_res_if.source res
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	// control state
	state_t         state_q, state_d;
	kind_t          kind_q;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic [IW-1:0]  k_q;
	logic           found_q;

	// walk payload
	logic [IW-1:0]     idx_q, lim_q, fpos_q;
	logic [DATA_W-1:0] val_q, rem_q;

	// cell row
	logic [DATA_W-1:0] ent [CAPACITY];
	logic [DATA_W-1:0] stk [CAPACITY];
	cell_ctl_t         ctl;
	logic [IW-1:0]     c_idx, tail;
	logic [DATA_W-1:0] head;

	// decode
	req_code_t rq;
	logic      acc, full, empty, pos_ok, ins_ok, need_scan;
	kind_t     scan_kind;
	logic [IW-1:0] scan_idx;

	// result path
	logic ob_full, push, step, last_step, hit;
	res_t pres;

	assign head = ent[0];
	assign tail = IW'(cnt_q - CW'(1));
	assign acc  = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && !ob_full;
	assign rq   = req_code_t'(req.req_type);
	assign full = (cnt_q == CW'(CAPACITY));
	assign empty = (cnt_q == '0);
	assign pos_ok = (req.position != '0) && (CMPW'(req.position) <= CMPW'(cnt_q));
	assign ins_ok = (req.position == POS_W'(1)) || pos_ok;
	assign hit  = (head == val_q);
	assign last_step = (k_q == lim_q);
	assign step = (kind_q != K_DUMP) || !ob_full;

	// request decode
	always_comb begin
		need_scan = 1'b0;
		scan_kind = K_DUMP;
		scan_idx  = '0;
		case (rq)
			RQ_DEL_BACK: begin
				need_scan = !empty;
				scan_kind = K_DEL;
				scan_idx  = tail;
			end
			RQ_DEL_AT: begin
				need_scan = pos_ok;
				scan_kind = K_DEL;
				scan_idx  = IW'(req.position - POS_W'(1));
			end
			RQ_SEARCH: begin
				need_scan = !empty;
				scan_kind = K_SRCH;
			end
			RQ_DUMP: begin
				need_scan = !empty;
				scan_kind = K_DUMP;
			end
			RQ_DUMP_REV: begin
				need_scan = !empty;
				scan_kind = K_DUMP_REV;
			end
			default: need_scan = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && need_scan) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (step && last_step) begin
					case (kind_q)
						K_DUMP:     state_d = ST_IDLE;
						K_DUMP_REV: state_d = ST_POP;
						default:    state_d = ST_RESP;
					endcase
				end
			end
			ST_POP: begin
				if (!ob_full && last_step) state_d = ST_IDLE;
			end
			ST_RESP: begin
				if (!ob_full) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// cell control, count and result
	always_comb begin
		ctl   = '{op: C_HOLD, sop: S_HOLD};
		c_idx = '0;
		cnt_d = cnt_q;
		push  = 1'b0;
		pres  = mk_res(ST_OK, '0, '0, '0, 1'b1);
		case (state_q)
			ST_IDLE: begin
				if (acc && !need_scan) begin
					push = 1'b1;
					case (rq)
						RQ_INS_FRONT, RQ_INS_BACK: begin
							if (full) begin
								pres.status = ST_FULL;
							end else begin
								ctl.op = C_INS;
								c_idx  = (rq == RQ_INS_FRONT) ? '0 : IW'(cnt_q);
								cnt_d  = cnt_q + CW'(1);
							end
						end
						RQ_INS_AT: begin
							if (!ins_ok) begin
								pres.status = ST_BADPOS;
							end else if (full) begin
								pres.status = ST_FULL;
							end else begin
								ctl.op = C_INS;
								c_idx  = IW'(req.position - POS_W'(1));
								cnt_d  = cnt_q + CW'(1);
							end
						end
						RQ_DEL_FRONT: begin
							if (empty) begin
								pres.status = ST_EMPTY;
							end else begin
								ctl.op    = C_DEL;
								c_idx     = '0;
								cnt_d     = cnt_q - CW'(1);
								pres.data = head;
							end
						end
						RQ_DEL_BACK, RQ_SEARCH, RQ_DUMP, RQ_DUMP_REV: begin
							pres.status = ST_EMPTY;
						end
						RQ_DEL_AT: begin
							pres.status = ST_BADPOS;
						end
						RQ_UPDATE: begin
							if (!pos_ok) begin
								pres.status = ST_BADPOS;
							end else begin
								ctl.op = C_WR;
								c_idx  = IW'(req.position - POS_W'(1));
							end
						end
						default: pres.status = ST_OK;
					endcase
				end
			end
			ST_SCAN: begin
				if (step) begin
					ctl.op = C_ROT;
					case (kind_q)
						K_DUMP: begin
							push      = 1'b1;
							pres.data = head;
							pres.pos  = OPOS_W'((IW + 1)'(k_q) + (IW + 1)'(1));
							pres.last = last_step;
						end
						K_DUMP_REV: begin
							ctl.sop = S_PUSH;
						end
						K_DEL: begin
							if (k_q == idx_q) begin
								ctl.op = C_DEL;
								c_idx  = '0;
								cnt_d  = cnt_q - CW'(1);
							end
						end
						default: ctl.op = C_ROT;
					endcase
				end
			end
			ST_POP: begin
				if (!ob_full) begin
					push      = 1'b1;
					ctl.sop   = S_POP;
					pres.data = stk[0];
					pres.pos  = OPOS_W'(cnt_q - CW'(k_q));
					pres.last = last_step;
				end
			end
			ST_RESP: begin
				if (!ob_full) begin
					push = 1'b1;
					if (kind_q == K_DEL) begin
						pres.data = rem_q;
					end else if (found_q) begin
						pres.pos = OPOS_W'((IW + 1)'(fpos_q) + (IW + 1)'(1));
					end else begin
						pres.status = ST_NOTFOUND;
					end
				end
			end
			default: push = 1'b0;
		endcase
		pres.cnt = OCNT_W'(cnt_d);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= K_DUMP;
			cnt_q   <= '0;
			k_q     <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == ST_IDLE && acc && need_scan) begin
				kind_q  <= scan_kind;
				found_q <= 1'b0;
			end
			if (state_q == ST_SCAN && step && kind_q == K_SRCH && hit && !found_q) begin
				found_q <= 1'b1;
			end
			if ((state_q == ST_SCAN && step) || (state_q == ST_POP && !ob_full)) begin
				k_q <= last_step ? '0 : k_q + IW'(1);
			end
		end
	end

	// walk payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc && need_scan) begin
			idx_q <= scan_idx;
			lim_q <= tail;
			val_q <= req.value;
		end
		if (state_q == ST_SCAN && kind_q == K_SRCH && hit && !found_q) begin
			fpos_q <= k_q;
		end
		if (state_q == ST_SCAN && kind_q == K_DEL && k_q == idx_q) begin
			rem_q <= head;
		end
	end

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] l_ent, r_ent, l_stk, r_stk;
		if (i == 0) begin : g_first
			assign l_ent = '0;
			assign l_stk = head;
		end else begin : g_mid_l
			assign l_ent = ent[i-1];
			assign l_stk = stk[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign r_ent = '0;
			assign r_stk = '0;
		end else begin : g_mid_r
			assign r_ent = ent[i+1];
			assign r_stk = stk[i+1];
		end
		ple_cell #(.IW(IW), .IDX(i)) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (c_idx),
			.tail      (tail),
			.value     (req.value),
			.head      (head),
			.left      (l_ent),
			.right     (r_ent),
			.stk_left  (l_stk),
			.stk_right (r_stk),
			.entry     (ent[i]),
			.stk       (stk[i])
		);
	end

	// result buffer
	ple_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (pres),
		.full   (ob_full),
		.res    (res)
	);

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_k_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> k_q == '0)
		else $error("walk counter not cleared when idle");

	a_cnt_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && kind_q != K_DEL) |=> cnt_q == $past(cnt_q))
		else $error("count changed during a read-only walk");

	a_pop_kind: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP |-> kind_q == K_DUMP_REV)
		else $error("stack pop outside a reverse dump");

	a_resp_kind: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESP |-> (kind_q == K_SRCH || kind_q == K_DEL))
		else $error("late response for a walk that has none");

endmodule

[hdl/ple_cell.sv]
// ple_cell: one slot of the list row, holding an entry and a stack word
// depends on ple_pkg

module ple_cell import ple_pkg::*; #(
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [IW-1:0]     idx,
	input  logic [IW-1:0]     tail,
	input  logic [DATA_W-1:0] value,
	input  logic [DATA_W-1:0] head,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	input  logic [DATA_W-1:0] stk_left,
	input  logic [DATA_W-1:0] stk_right,
	output logic [DATA_W-1:0] entry,
	output logic [DATA_W-1:0] stk
);

	localparam logic [IW-1:0] ME = IW'(IDX);

	logic [DATA_W-1:0] entry_q, entry_d;
	logic [DATA_W-1:0] stk_q, stk_d;

	// entry move
	always_comb begin
		entry_d = entry_q;
		case (ctl.op)
			C_HOLD: entry_d = entry_q;
			C_INS: begin
				if (ME > idx) entry_d = left;
				else if (ME == idx) entry_d = value;
			end
			C_DEL: begin
				if (ME >= idx) entry_d = right;
			end
			C_ROT: begin
				if (ME == tail) entry_d = head;
				else if (ME < tail) entry_d = right;
			end
			C_WR: begin
				if (ME == idx) entry_d = value;
			end
			default: entry_d = entry_q;
		endcase
	end

	// stack move, top of stack sits in cell zero
	always_comb begin
		case (ctl.sop)
			S_PUSH:  stk_d = stk_left;
			S_POP:   stk_d = stk_right;
			default: stk_d = stk_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
		stk_q   <= stk_d;
	end

	assign entry = entry_q;
	assign stk   = stk_q;

endmodule

[hdl/ple_obuf.sv]
// ple_obuf: two-entry result buffer in front of the result channel
// depends on ple_pkg and ple_res_if

module ple_obuf import ple_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  res_t  din,
	output logic  full,
	ple_res_if.source res
);

	logic [1:0] fill_q;
	res_t       e0_q, e1_q;
	logic       pop;

	assign pop  = res.valid && res.ready;
	assign full = (fill_q == 2'd2);

	// fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else begin
			if (push && !pop) fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

	// storage, head in e0
	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (fill_q == 2'd1) e0_q <= din;
		end else if (push) begin
			if (fill_q == 2'd0) e0_q <= din;
			else e1_q <= din;
		end else if (pop) begin
			e0_q <= e1_q;
		end
	end

	assign res.valid        = (fill_q != 2'd0);
	assign res.status       = e0_q.status;
	assign res.data_out     = e0_q.data;
	assign res.position_out = e0_q.pos;
	assign res.entry_count  = e0_q.cnt;
	assign res.last         = e0_q.last;

endmodule
